[rtl/core/pfba_pkg.sv]
// Shared constants and types of the page frame bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package pfba_pkg;

  localparam int unsigned MAX_FRAMES    = 4096;
  localparam int unsigned MAP_WORD_BITS = 32;
  localparam int unsigned MAP_WORDS     = MAX_FRAMES / MAP_WORD_BITS;
  localparam int unsigned WORD_IDX_W    = $clog2(MAP_WORDS);
  localparam int unsigned BIT_IDX_W     = $clog2(MAP_WORD_BITS);
  localparam int unsigned FRAME_W       = 12;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned IN_DATA_W     = 16;
  localparam int unsigned OUT_DATA_W    = 24;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(MAX_FRAMES);

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_TEST  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MAPPED   = 2'd1,
    ST_NO_FRAME = 2'd2
  } status_e;

  // Result item, highest field first so that status lands in the lowest bits.
  typedef struct packed {
    logic               in_use;
    logic               writable_flag;
    logic               user_flag;
    logic               present_flag;
    logic [FRAME_W-1:0] result_frame;
    logic [1:0]         status;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/page_frame_bitmap_allocator.sv]
// Top level of the first-fit bitmap page frame allocator.
//
// Requests arrive on the s_axis channel: tdata carries mode, frame_index,
// kernel_only and write_access. Mode allocate finds the lowest free frame below
// memory_frames (capped at 4096), marks it used and returns it with the entry
// flags; an entry that already holds a nonzero frame is refused as already
// mapped, and a full map returns no free frame. Mode free clears a frame's bit,
// mode test reports whether a frame is used. Every request yields exactly one
// result transfer on the m_axis channel.
// The used map lives in a 128 x 32 RAM with a registered read. An allocate reads
// one map word per cycle, starting at word 0, until it finds a free frame or
// reaches the limit. Free and test do one read-modify-write; a refused
// allocate and the unused mode skip the map. One request is worked on at a
// time; a new request is taken once the previous result sits in the output
// register, even while the receiver has not yet taken it.
// Reset clears a valid bit per map word, so every frame reads as free at once,
// and sets memory_frames to 4096. If the receiver stalls, the result waits in
// the output register and a finished next result waits in the core, which then
// takes no further request. memory_frames may be written only while idle.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_bitmap_allocator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration: memory_frames.
  input  wire logic                           cfg_we_i,
  input  wire logic [pfba_pkg::CFG_W-1:0]     cfg_wdata_i,
  // Requests. tdata: mode[1:0], frame_index[13:2], kernel_only[14],
  // write_access[15].
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [pfba_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // Results. tdata: status[1:0], result_frame[13:2], present_flag[14],
  // user_flag[15], writable_flag[16], in_use[17], zeros[23:18].
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [pfba_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  import pfba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_DONE
  } state_e;

  state_e                 state_q;
  mode_e                  mode_q;
  logic [BIT_IDX_W-1:0]   bit_q;
  logic                   kern_q;
  logic                   wr_q;
  logic [CFG_W-1:0]       frames_q;
  logic [CFG_W-1:0]       limit_q;
  logic [WORD_IDX_W-1:0]  word_q;
  res_t                   res_q;
  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic [MAP_WORDS-1:0]   vld_q;
  logic                   rd_vld_q;

  // Request fields.
  mode_e                 in_mode;
  logic [FRAME_W-1:0]    in_frame;
  logic                  in_kern;
  logic                  in_wr;
  logic                  in_xfer;
  res_t                  res_init;
  logic                  res_push;

  assign in_mode  = mode_e'(s_axis_tdata_i[1:0]);
  assign in_frame = s_axis_tdata_i[FRAME_W+1:2];
  assign in_kern  = s_axis_tdata_i[FRAME_W+2];
  assign in_wr    = s_axis_tdata_i[FRAME_W+3];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // The finished result moves to the output register once that is free.
  assign res_push = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  // Starting result of a new request; only a refused allocate sets a field here.
  always_comb begin
    res_init = '0;
    if ((in_mode == MODE_ALLOC) && (in_frame != '0)) begin
      res_init.status = ST_MAPPED;
    end
  end

  // Map RAM ports.
  logic [WORD_IDX_W-1:0]    ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_rdata;
  logic                     ram_we;
  logic [MAP_WORD_BITS-1:0] ram_wdata;

  pfba_ram #(
    .Width(MAP_WORD_BITS),
    .Depth(MAP_WORDS)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(word_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A word never written since reset reads as all free.
  logic [MAP_WORD_BITS-1:0] rd_word;
  assign rd_word = rd_vld_q ? ram_rdata : '0;

  // Read address: the first word to look at on a new request, else the word
  // after the one under inspection so that the scan moves a word per cycle.
  always_comb begin
    if (state_q == S_IDLE) begin
      ram_raddr = (in_mode == MODE_ALLOC) ? '0 : in_frame[FRAME_W-1:BIT_IDX_W];
    end else begin
      ram_raddr = word_q + WORD_IDX_W'(1);
    end
  end

  // Frame range of the current word and the mask of frames below the limit.
  logic [CFG_W-1:0]         word_base;
  logic [CFG_W-1:0]         word_end;
  logic [MAP_WORD_BITS-1:0] lim_mask;
  logic [MAP_WORD_BITS-1:0] free_bits;
  logic                     found;
  logic [BIT_IDX_W-1:0]     found_bit;
  logic                     last_word;

  assign word_base = {1'b0, word_q, {BIT_IDX_W{1'b0}}};
  assign word_end  = {({1'b0, word_q} + (WORD_IDX_W + 1)'(1)), {BIT_IDX_W{1'b0}}};
  assign last_word = (word_end >= limit_q);

  always_comb begin
    if (limit_q >= word_end) begin
      lim_mask = '1;
    end else if (limit_q <= word_base) begin
      lim_mask = '0;
    end else begin
      lim_mask = (MAP_WORD_BITS'(1) << limit_q[BIT_IDX_W-1:0]) - MAP_WORD_BITS'(1);
    end
  end

  assign free_bits = ~rd_word & lim_mask;
  assign found     = |free_bits;

  // Lowest free bit of the word.
  always_comb begin
    found_bit = '0;
    for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        found_bit = BIT_IDX_W'(b);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = rd_word;
    case (state_q)
      S_SCAN: begin
        ram_we    = found;
        ram_wdata = rd_word | (MAP_WORD_BITS'(1) << found_bit);
      end
      S_RMW: begin
        ram_we    = (mode_q == MODE_FREE);
        ram_wdata = rd_word & ~(MAP_WORD_BITS'(1) << bit_q);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_ALLOC;
      bit_q       <= '0;
      kern_q      <= 1'b0;
      wr_q        <= 1'b0;
      frames_q    <= FRAMES_RESET;
      limit_q     <= '0;
      word_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[ram_raddr];
      if (ram_we) begin
        vld_q[word_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        frames_q <= cfg_wdata_i;
      end
      if (res_push) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            mode_q  <= in_mode;
            bit_q   <= in_frame[BIT_IDX_W-1:0];
            kern_q  <= in_kern;
            wr_q    <= in_wr;
            limit_q <= (frames_q > FRAMES_RESET) ? FRAMES_RESET : frames_q;
            res_q   <= res_init;
            case (in_mode)
              MODE_ALLOC: begin
                word_q <= '0;
                if (in_frame != '0) begin
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              MODE_FREE, MODE_TEST: begin
                word_q  <= in_frame[FRAME_W-1:BIT_IDX_W];
                state_q <= S_RMW;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (found) begin
            res_q.status        <= ST_OK;
            res_q.result_frame  <= {word_q, found_bit};
            res_q.present_flag  <= 1'b1;
            res_q.user_flag     <= ~kern_q;
            res_q.writable_flag <= wr_q;
            state_q             <= S_DONE;
          end else if (last_word) begin
            res_q.status <= ST_NO_FRAME;
            state_q      <= S_DONE;
          end else begin
            word_q <= word_q + WORD_IDX_W'(1);
          end
        end
        S_RMW: begin
          if (mode_q == MODE_TEST) begin
            res_q.in_use <= rd_word[bit_q];
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (res_push) begin
            out_data_q <= OUT_DATA_W'(res_q);
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/pfba_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pfba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the first-fit bitmap page frame allocator.
`timescale 1ns / 1ps

module tb_top;

  import pfba_pkg::*;

  // Mode 3 has no meaning in the block; it must return an all-zero result.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idling_e;

  // Mirror of the frame bitmap and of memory_frames. It turns every accepted
  // request into the result the block must return and checks results in order.
  class frame_map_scoreboard;
    bit [MAX_FRAMES-1:0]  used_frames;
    logic [CFG_W-1:0]     frame_count;
    res_t                 expected_q[$];
    int unsigned          high_water;
    int unsigned          errors;

    function new();
      used_frames = '0;
      frame_count = FRAMES_RESET;
      high_water  = 0;
      errors      = 0;
    endfunction

    function void set_frame_count(logic [CFG_W-1:0] frames);
      frame_count = frames;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Predicts the result of one accepted request and updates the bitmap.
    function void note_request(logic [IN_DATA_W-1:0] req);
      logic [1:0]         mode;
      logic [FRAME_W-1:0] idx;
      logic               kern;
      logic               wr;
      int unsigned        limit;
      bit                 found;
      res_t               r;
      mode  = req[1:0];
      idx   = req[13:2];
      kern  = req[14];
      wr    = req[15];
      r     = '0;
      found = 1'b0;
      case (mode)
        MODE_ALLOC: begin
          if (idx != '0) begin
            r.status = ST_MAPPED;
          end else begin
            // Frame counts above the map size act as the map size.
            limit = (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
            for (int f = 0; f < limit && !found; f++) begin
              if (!used_frames[f]) begin
                found          = 1'b1;
                used_frames[f] = 1'b1;
                r.status       = ST_OK;
                r.result_frame = FRAME_W'(f);
                r.present_flag = 1'b1;
                r.user_flag    = ~kern;
                r.writable_flag = wr;
                if (f + 1 > high_water) high_water = f + 1;
              end
            end
            if (!found) r.status = ST_NO_FRAME;
          end
        end
        MODE_FREE: begin
          used_frames[idx] = 1'b0;
        end
        MODE_TEST: begin
          r.in_use = used_frames[idx];
        end
        default: begin
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [FRAME_W-1:0] want,
                                logic [FRAME_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_result(logic [OUT_DATA_W-1:0] data);
      res_t want;
      res_t got;
      if (expected_q.size() == 0) begin
        $display("%0t: result %h arrived with no request outstanding, expected none",
                 $time, data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      got  = res_t'(data[17:0]);
      compare_field("status", FRAME_W'(want.status), FRAME_W'(got.status));
      compare_field("result_frame", want.result_frame, got.result_frame);
      compare_field("present_flag", FRAME_W'(want.present_flag),
                    FRAME_W'(got.present_flag));
      compare_field("user_flag", FRAME_W'(want.user_flag), FRAME_W'(got.user_flag));
      compare_field("writable_flag", FRAME_W'(want.writable_flag),
                    FRAME_W'(got.writable_flag));
      compare_field("in_use", FRAME_W'(want.in_use), FRAME_W'(got.in_use));
      compare_field("padding", '0, FRAME_W'(data[OUT_DATA_W-1:18]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic                  rcv_hold = 1'b0;
  int unsigned           src_idle_pct = 0;
  int unsigned           rcv_stall_pct = 0;
  event                  hold_off_ev;

  frame_map_scoreboard   sb = new();

  page_frame_bitmap_allocator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: random stalls, plus a long hold-off on request so that the core
  // fills up and has to stall its request channel.
  always @(posedge clk_i) begin
    m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_stall_pct);
  end

  initial begin
    forever begin
      @(hold_off_ev);
      rcv_hold <= 1'b1;
      repeat (400) @(posedge clk_i);
      rcv_hold <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_request(logic [1:0] mode,
      logic [FRAME_W-1:0] idx, logic kern, logic wr);
    return {wr, kern, idx, mode};
  endfunction

  // Mostly frames near the allocated region so that frees and tests hit used
  // frames; sometimes any frame of the whole index range.
  function automatic logic [FRAME_W-1:0] pick_frame();
    int unsigned top;
    top = (sb.high_water > 4095) ? 4095 : sb.high_water;
    if ($urandom_range(99) < 80) return FRAME_W'($urandom_range(top));
    return FRAME_W'($urandom_range(4095));
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_request();
    int unsigned pick;
    logic        kern;
    logic        wr;
    pick = $urandom_range(99);
    kern = 1'($urandom_range(1));
    wr   = 1'($urandom_range(1));
    if (pick < 45) return pack_request(MODE_ALLOC, '0, kern, wr);
    if (pick < 52) return pack_request(MODE_ALLOC, FRAME_W'($urandom_range(4095, 1)), kern, wr);
    if (pick < 75) return pack_request(MODE_FREE, pick_frame(), kern, wr);
    if (pick < 95) return pack_request(MODE_TEST, pick_frame(), kern, wr);
    return pack_request(MODE_UNUSED, FRAME_W'($urandom_range(4095)), kern, wr);
  endfunction

  // Offers one request, waits for its transfer and then leaves a random gap.
  // Valid stays high across back-to-back requests.
  task automatic push_request(input logic [IN_DATA_W-1:0] req);
    int unsigned gap;
    gap = 0;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req);
    while ($urandom_range(99) < src_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // memory_frames may only change while the block is idle, so the sender
  // pauses until every outstanding result has been taken.
  task automatic set_frames(input logic [CFG_W-1:0] frames);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= frames;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_frame_count(frames);
  endtask

  task automatic set_idling(input idling_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct = 0;
        rcv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        src_idle_pct = 77;
        rcv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        src_idle_pct = 0;
        rcv_stall_pct = 77;
      end
      default: begin
        src_idle_pct = 17;
        rcv_stall_pct = 17;
      end
    endcase
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] frames, input idling_e mode,
                           input int unsigned count, input bit long_hold);
    set_frames(frames);
    set_idling(mode);
    if (long_hold) -> hold_off_ev;
    repeat (count) push_request(random_request());
    end_burst();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset frame count of 4096.
    set_idling(IDLE_NONE);
    push_request(pack_request(MODE_ALLOC, 12'd0, 1'b0, 1'b0));
    push_request(pack_request(MODE_ALLOC, 12'd0, 1'b1, 1'b1));
    push_request(pack_request(MODE_ALLOC, 12'd0, 1'b0, 1'b1));
    push_request(pack_request(MODE_ALLOC, 12'd0, 1'b1, 1'b0));
    // Entries that already hold a frame are refused.
    push_request(pack_request(MODE_ALLOC, 12'd4095, 1'b0, 1'b1));
    push_request(pack_request(MODE_ALLOC, 12'd1, 1'b1, 1'b1));
    push_request(pack_request(MODE_TEST, 12'd0, 1'b0, 1'b0));
    push_request(pack_request(MODE_TEST, 12'd4095, 1'b1, 1'b1));
    push_request(pack_request(MODE_TEST, 12'd3, 1'b0, 1'b0));
    // Freeing frame zero really clears its bit, so the next allocate reuses it.
    push_request(pack_request(MODE_FREE, 12'd0, 1'b0, 1'b0));
    push_request(pack_request(MODE_TEST, 12'd0, 1'b0, 1'b0));
    push_request(pack_request(MODE_ALLOC, 12'd0, 1'b1, 1'b1));
    push_request(pack_request(MODE_FREE, 12'd4095, 1'b1, 1'b1));
    push_request(pack_request(MODE_FREE, 12'd2, 1'b0, 1'b0));
    push_request(pack_request(MODE_ALLOC, 12'd0, 1'b0, 1'b1));
    push_request(pack_request(MODE_UNUSED, 12'd4095, 1'b1, 1'b1));
    push_request(pack_request(MODE_UNUSED, 12'd0, 1'b0, 1'b0));
    push_request(pack_request(MODE_TEST, 12'd2, 1'b1, 1'b0));
    end_burst();

    // No frame exists at all: allocate fails and changes nothing.
    set_frames(13'd0);
    push_request(pack_request(MODE_ALLOC, 12'd0, 1'b0, 1'b1));
    push_request(pack_request(MODE_FREE, 12'd5, 1'b0, 1'b0));
    push_request(pack_request(MODE_TEST, 12'd1, 1'b0, 1'b0));
    end_burst();

    // Random phases over several frame counts; the small ones run the map full.
    run_phase(13'd8191, IDLE_NONE, 80, 1'b0);
    run_phase(13'd40, IDLE_SENDER, 80, 1'b0);
    run_phase(13'd1, IDLE_RECEIVER, 40, 1'b0);
    run_phase(13'd4096, IDLE_BOTH, 100, 1'b1);
    run_phase(13'd4095, IDLE_NONE, 60, 1'b1);
    run_phase(13'd0, IDLE_BOTH, 30, 1'b0);
    run_phase(13'd100, IDLE_RECEIVER, 80, 1'b0);
    run_phase(13'd4097, IDLE_SENDER, 60, 1'b0);
    run_phase(13'd33, IDLE_NONE, 70, 1'b0);

    wait_drained();
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
